@@ hdl/fit_pkg.sv @@
// shared constants and types for the fault injection table
package fit_pkg;
  localparam int unsigned SLOT_COUNT_DEF = 8;
  localparam int unsigned KEY_BITS_DEF = 16;
  localparam int unsigned IN_KEY_W = 16;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned MODE_W = 2;
  localparam logic [31:0] LCG_MUL = 32'd1664525;
  localparam logic [31:0] LCG_ADD = 32'd1013904223;
  localparam logic [15:0] PERCENT_RANGE = 16'd100;
  localparam int unsigned DRAW_SHIFT = 16;

  typedef enum logic [1:0] {
    MODE_ONCE    = 2'd0,
    MODE_AFTER_N = 2'd1,
    MODE_EVERY_N = 2'd2,
    MODE_PROB    = 2'd3
  } mode_t;

  localparam logic OP_CONFIG = 1'b0;
  localparam logic OP_QUERY  = 1'b1;
endpackage

@@ hdl/fit_ram.sv @@
// generic ram with one write port and one registered read port
module fit_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ hdl/fault_injection_table.sv @@
// fault injection table: slot scan over the entry and hit rams, per-mode decision, result register
// sequencing: configure and query scan k slots (1..SLOT_COUNT), each via S_CHECK then S_READ;
//   a query hit goes on via S_DIV and S_DRAW for every-n, S_LCG and S_DRAW for probability
// throughput: one word at a time; next word accepted once the result register is free
//   and the scan is done; the ram read port is the limiting resource
// reset: rst_n synchronous active low clears armed bits, lcg state to one, output empty
module fault_injection_table
  import fit_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // op[0], key[16:1], mode[18:17], value[50:19], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // status[0], fail[1], fired_mode[3:2], zero pad
);
  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned RD = (SLOT_COUNT > 1) ? SLOT_COUNT : 2;
  localparam int unsigned EW = KEY_BITS + MODE_W + VAL_W;
  localparam int unsigned CW = (SW + 1 > 6) ? SW + 1 : 6;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_CHECK, S_DIV, S_LCG, S_DRAW, S_DONE
  } state_t;

  state_t state_r;
  logic [SW:0] slot_r;
  logic op_r;
  logic [KEY_BITS-1:0] key_r;
  logic [MODE_W-1:0] mode_r;
  logic [VAL_W-1:0] value_r;
  logic [SLOT_COUNT-1:0] armed_r;
  logic [31:0] lcg_r, hits_r, rem_r;
  logic [CW-1:0] cnt_r;
  logic status_r, fail_r;
  logic [1:0] fmode_r;
  logic ovalid_r;

  // entry ram holds key, mode, value; hits ram holds counts
  logic ent_we, hit_we;
  logic [EW-1:0] ent_wdata, ent_rdata;
  logic [31:0] hit_wdata, hit_rdata;
  logic [SW-1:0] idx;

  assign idx = slot_r[SW-1:0];

  fit_ram #(.WIDTH(EW), .DEPTH(RD)) u_ent (
    .clk, .we(ent_we), .waddr(idx), .wdata(ent_wdata), .raddr(idx), .rdata(ent_rdata)
  );
  fit_ram #(.WIDTH(32), .DEPTH(RD)) u_hit (
    .clk, .we(hit_we), .waddr(idx), .wdata(hit_wdata), .raddr(idx), .rdata(hit_rdata)
  );

  logic [KEY_BITS-1:0] e_key;
  logic [MODE_W-1:0] e_mode;
  logic [VAL_W-1:0] e_val;
  logic [KEY_BITS-1:0] in_key;
  logic [31:0] hits_inc;
  logic slot_armed, key_eq, cfg_hit, qry_hit, last_slot;
  logic [32:0] rem_sh;
  logic [31:0] lcg_step;
  logic [15:0] draw;

  assign e_key  = ent_rdata[KEY_BITS-1:0];
  assign e_mode = ent_rdata[KEY_BITS +: MODE_W];
  assign e_val  = ent_rdata[KEY_BITS+MODE_W +: VAL_W];
  assign in_key = KEY_BITS'(in_tdata[16:1]);
  assign slot_armed = armed_r[idx];
  assign key_eq = (e_key == key_r);
  assign cfg_hit = !slot_armed || key_eq;
  assign qry_hit = slot_armed && key_eq;
  assign last_slot = (slot_r == (SW+1)'(SLOT_COUNT - 1));
  assign hits_inc = hit_rdata + 32'd1;
  assign rem_sh = {rem_r, hits_r[31]};
  assign lcg_step = lcg_r * LCG_MUL + LCG_ADD;
  assign draw = lcg_r[31:DRAW_SHIFT];

  assign ent_we = (state_r == S_READ) && (op_r == OP_CONFIG) && cfg_hit;
  assign ent_wdata = {value_r, mode_r, key_r};
  assign hit_we = (state_r == S_READ) && (op_r == OP_CONFIG ? cfg_hit : qry_hit);
  assign hit_wdata = (op_r == OP_CONFIG) ? 32'd0 : hits_inc;

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata = {4'd0, fmode_r, fail_r, status_r};

  // S_READ here means address presented last cycle, data valid now
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      armed_r  <= '0;
      lcg_r    <= 32'd1;
      ovalid_r <= 1'b0;
      slot_r   <= '0;
    end else begin
      if (cfg_we) begin
        lcg_r <= (cfg_wdata == 32'd0) ? 32'd1 : cfg_wdata;
      end
      if (ovalid_r && out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r    <= in_tdata[0];
            key_r   <= in_key;
            mode_r  <= in_tdata[18:17];
            value_r <= in_tdata[50:19];
            slot_r  <= '0;
            status_r <= 1'b0;
            fail_r  <= 1'b0;
            fmode_r <= '0;
            state_r <= S_CHECK;
          end
        end
        S_CHECK: state_r <= S_READ;  // ram read in flight
        S_READ: begin
          if (op_r == OP_CONFIG) begin
            if (cfg_hit) begin
              armed_r[idx] <= 1'b1;
              state_r <= S_DONE;
            end else if (last_slot) begin
              status_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              slot_r <= slot_r + 1'b1;
              state_r <= S_CHECK;
            end
          end else if (qry_hit) begin
            hits_r <= hits_inc;
            value_r <= e_val;
            mode_r <= e_mode;
            fmode_r <= e_mode;
            rem_r <= '0;
            cnt_r <= '0;
            case (mode_t'(e_mode))
              MODE_ONCE: begin
                if (hits_inc == 32'd1) begin
                  armed_r[idx] <= 1'b0;
                  fail_r <= 1'b1;
                end
                state_r <= S_DONE;
              end
              MODE_AFTER_N: begin
                fail_r <= (hits_inc > e_val);
                state_r <= S_DONE;
              end
              MODE_EVERY_N: state_r <= (e_val != 32'd0) ? S_DIV : S_DONE;
              MODE_PROB: state_r <= S_LCG;
              default: state_r <= S_DONE;
            endcase
          end else if (last_slot) begin
            state_r <= S_DONE;
          end else begin
            slot_r <= slot_r + 1'b1;
            state_r <= S_CHECK;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          hits_r <= {hits_r[30:0], 1'b0};
          if (rem_sh >= {1'b0, value_r}) begin
            rem_r <= 32'(rem_sh - {1'b0, value_r});
          end else begin
            rem_r <= rem_sh[31:0];
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(31)) begin
            state_r <= S_DRAW;
          end
        end
        S_LCG: begin
          lcg_r <= lcg_step;
          state_r <= S_DRAW;
        end
        S_DRAW: begin
          if (mode_r == MODE_PROB && fmode_r == MODE_PROB) begin
            // draw mod 100 via quotient estimate and one correction
            rem_r <= 32'(draw) - 32'(32'(draw) * 32'd655 >> 16) * 32'(PERCENT_RANGE);
            mode_r <= MODE_ONCE;
            state_r <= S_DRAW;
          end else if (fmode_r == MODE_PROB) begin
            if (rem_r >= 32'(PERCENT_RANGE)) begin
              fail_r <= (value_r != 0) && ((rem_r - 32'(PERCENT_RANGE)) < value_r);
            end else begin
              fail_r <= (value_r != 0) && (rem_r < value_r);
            end
            state_r <= S_DONE;
          end else begin
            fail_r <= (rem_r == 32'd0);
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!fail_r) fmode_r <= '0;
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ hdl/fit_checker.sv @@
// port-level checks for the fault injection table
module fit_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");
  a_nomix: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("status and fail both set");
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[3:2] == 2'd0)
    else $error("fired mode without fail");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while busy");
endmodule

bind fault_injection_table fit_checker u_fit_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
